>>> src/irm_pkg.sv
package irm_pkg;

    localparam int CAPACITY = 32;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int N_W      = $clog2(CAPACITY + 3);
    localparam int ENT_W    = KEY_W + VALUE_W;

    localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    localparam logic REQ_ASSIGN = 1'b0;
    localparam logic REQ_CANON  = 1'b1;

    typedef enum logic [1:0] {
        ST_APPLIED = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic load_req;
        logic scan_start;
        logic proc_entry;
        logic wr_begin;
        logic wr_end;
        logic commit;
        logic set_ignored;
        logic dump_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic req_canon;
        logic req_invalid;
        logic at_end;
        logic need_ins;
        logic ins_done;
        logic out_taken;
        logic out_last;
    } t_stat;

endpackage

>>> src/interval_range_map_core.sv
// Interval range map: keeps a sorted table of up to 32 range start keys with values
// in two ping-pong RAMs (one registered read per cycle). An assign request scans the
// stored entries and inserts its begin and end keys; a canonicalise request merges
// equal neighbours. Then the full table is dumped one entry at a time, waiting while
// the output is stalled. The input stall is high from acceptance until the last
// entry of the dump has been taken. base_value may be written only while idle.
module interval_range_map_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [irm_pkg::VALUE_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic signed [irm_pkg::KEY_W-1:0]    i_key_begin,
    input  logic signed [irm_pkg::KEY_W-1:0]    i_key_end,
    input  logic [irm_pkg::VALUE_W-1:0]         i_new_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [irm_pkg::KEY_W-1:0]    o_entry_key,
    output logic [irm_pkg::VALUE_W-1:0]         o_entry_value,
    output logic                                o_last_entry,
    output logic [1:0]                          o_status
);
    import irm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    irm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    irm_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_key_begin   (i_key_begin),
        .i_key_end     (i_key_end),
        .i_new_value   (i_new_value),
        .o_entry_key   (o_entry_key),
        .o_entry_value (o_entry_value),
        .o_last_entry  (o_last_entry),
        .o_status      (o_status),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall)
    );

endmodule

>>> src/irm_ram.sv
module irm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/irm_datapath.sv
module irm_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  irm_pkg::t_cmd                       i_cmd,
    output irm_pkg::t_stat                      o_stat,
    input  logic                                i_cfg_we,
    input  logic [irm_pkg::VALUE_W-1:0]         i_cfg_data,
    input  logic                                i_req_type,
    input  logic signed [irm_pkg::KEY_W-1:0]    i_key_begin,
    input  logic signed [irm_pkg::KEY_W-1:0]    i_key_end,
    input  logic [irm_pkg::VALUE_W-1:0]         i_new_value,
    output logic signed [irm_pkg::KEY_W-1:0]    o_entry_key,
    output logic [irm_pkg::VALUE_W-1:0]         o_entry_value,
    output logic                                o_last_entry,
    output logic [1:0]                          o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_stall
);
    import irm_pkg::*;

    logic                     r_req_type;
    logic signed [KEY_W-1:0]  r_kb;
    logic signed [KEY_W-1:0]  r_ke;
    logic [VALUE_W-1:0]       r_nv;
    logic [VALUE_W-1:0]       r_base;
    logic                     r_bank;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_idx;
    logic [N_W-1:0]           r_n;
    logic                     r_ins_done;
    logic [VALUE_W-1:0]       r_old;
    logic [VALUE_W-1:0]       r_prev;
    t_status                  r_status;
    logic                     r_out_valid;
    logic signed [KEY_W-1:0]  r_out_key;
    logic [VALUE_W-1:0]       r_out_val;
    logic                     r_out_last;

    logic [ENT_W-1:0]         w_q0;
    logic [ENT_W-1:0]         w_q1;
    logic [ENT_W-1:0]         w_q;
    logic signed [KEY_W-1:0]  w_key;
    logic [VALUE_W-1:0]       w_val;
    logic                     w_sentinel;
    logic                     w_keep;
    logic                     w_wr;
    logic                     w_we;
    logic [ENT_W-1:0]         w_wdata;
    logic                     w_full;

    // sentinel entry at index 0 always reads as min key with base value, whatever RAM slot 0 holds
    assign w_q        = r_bank ? w_q1 : w_q0;
    assign w_sentinel = (r_idx == '0);
    assign w_key      = w_sentinel ? KEY_MIN : w_q[ENT_W-1:VALUE_W];
    assign w_val      = w_sentinel ? r_base : w_q[VALUE_W-1:0];
    assign w_full     = (r_n > N_W'(CAPACITY));

    always_comb begin
        if (r_req_type == REQ_CANON) begin
            w_keep = w_sentinel || (w_val != r_prev);
        end else begin
            w_keep = (w_key < r_kb) || (w_key > r_ke);
        end
    end

    always_comb begin
        w_wr    = 1'b0;
        w_wdata = {w_key, w_val};
        if (i_cmd.wr_begin) begin
            w_wr    = 1'b1;
            w_wdata = {r_kb, r_nv};
        end else if (i_cmd.wr_end) begin
            w_wr    = 1'b1;
            w_wdata = {r_ke, r_old};
        end else if (i_cmd.proc_entry) begin
            w_wr    = w_keep;
        end
    end

    assign w_we = w_wr && (r_n < N_W'(CAPACITY));

    irm_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (w_we && r_bank),
        .i_waddr (r_n[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_q0)
    );

    irm_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (w_we && !r_bank),
        .i_waddr (r_n[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_q1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_bank      <= 1'b0;
            r_count     <= CNT_W'(1);
            r_status    <= ST_APPLIED;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_n         <= '0;
            r_ins_done  <= 1'b0;
            r_req_type  <= REQ_ASSIGN;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (i_cmd.load_req) begin
                r_req_type <= i_req_type;
                r_kb       <= i_key_begin;
                r_ke       <= i_key_end;
                r_nv       <= i_new_value;
            end
            if (i_cmd.scan_start) begin
                r_idx      <= '0;
                r_n        <= '0;
                r_ins_done <= 1'b0;
            end
            if (i_cmd.proc_entry) begin
                if (w_keep) begin
                    r_n <= r_n + N_W'(1);
                end
                if (w_key <= r_ke) begin
                    r_old <= w_val;
                end
                r_prev <= w_val;
                r_idx  <= r_idx + CNT_W'(1);
            end
            if (i_cmd.wr_begin) begin
                r_n <= r_n + N_W'(1);
            end
            if (i_cmd.wr_end) begin
                r_n        <= r_n + N_W'(1);
                r_ins_done <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_req_type == REQ_CANON || !w_full) begin
                    r_bank   <= !r_bank;
                    r_count  <= r_n[CNT_W-1:0];
                    r_status <= ST_APPLIED;
                end else begin
                    r_status <= ST_FULL;
                end
            end
            if (i_cmd.set_ignored) begin
                r_status <= ST_IGNORED;
            end
            if (i_cmd.dump_start) begin
                r_idx <= '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                r_out_key   <= w_key;
                r_out_val   <= w_val;
                r_out_last  <= (r_idx + CNT_W'(1) == r_count);
                r_idx       <= r_idx + CNT_W'(1);
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.req_canon   = (r_req_type == REQ_CANON);
    assign o_stat.req_invalid = !(r_kb < r_ke) || (r_kb == KEY_MIN) || (r_nv == r_base);
    assign o_stat.at_end      = (r_idx == r_count);
    assign o_stat.need_ins    = !r_ins_done && (w_key > r_ke);
    assign o_stat.ins_done    = r_ins_done;
    assign o_stat.out_taken   = r_out_valid && !i_out_stall;
    assign o_stat.out_last    = r_out_last;

    assign o_entry_key   = r_out_key;
    assign o_entry_value = r_out_val;
    assign o_last_entry  = r_out_last;
    assign o_status      = r_status;
    assign o_out_valid   = r_out_valid;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 && r_count <= CNT_W'(CAPACITY))
        else $error("entry count out of range");

    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_stall |=> !r_out_valid)
        else $error("output held after being taken");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_req_type == REQ_ASSIGN && w_full |=> $stable(r_count) && $stable(r_bank))
        else $error("full request changed the table");

endmodule

>>> src/irm_ctrl.sv
module irm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  irm_pkg::t_stat i_stat,
    output irm_pkg::t_cmd  o_cmd
);
    import irm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD,
        S_PROC,
        S_INS_B,
        S_INS_E,
        S_COMMIT,
        S_DRD,
        S_DLD,
        S_DWAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   n_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.req_canon && i_stat.req_invalid) begin
                    o_cmd.set_ignored = 1'b1;
                    o_cmd.dump_start  = 1'b1;
                    n_state           = S_DRD;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_RD;
                end
            end
            S_RD: begin
                if (i_stat.at_end) begin
                    if (!i_stat.req_canon && !i_stat.ins_done) begin
                        n_state = S_INS_B;
                    end else begin
                        n_state = S_COMMIT;
                    end
                end else begin
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                if (!i_stat.req_canon && i_stat.need_ins) begin
                    n_state = S_INS_B;
                end else begin
                    o_cmd.proc_entry = 1'b1;
                    n_state          = S_RD;
                end
            end
            S_INS_B: begin
                o_cmd.wr_begin = 1'b1;
                n_state        = S_INS_E;
            end
            S_INS_E: begin
                o_cmd.wr_end = 1'b1;
                n_state      = S_RD;
            end
            S_COMMIT: begin
                o_cmd.commit     = 1'b1;
                o_cmd.dump_start = 1'b1;
                n_state          = S_DRD;
            end
            S_DRD: begin
                n_state = S_DLD;
            end
            S_DLD: begin
                o_cmd.load_out = 1'b1;
                n_state        = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.out_taken) begin
                    n_state = i_stat.out_last ? S_IDLE : S_DRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_in_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

    assign o_in_stall = r_in_stall;

    a_stall_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_stall == (r_state != S_IDLE))
        else $error("stall out of step with state");

endmodule

>>> dv/interval_range_map_core_tb.sv
`timescale 1ns / 100ps

module interval_range_map_core_tb;
    import irm_pkg::*;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] kbeg;
        logic [KEY_W-1:0] kend;
        logic [VALUE_W-1:0] val;
    } t_req;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] val;
        logic               last;
        logic [1:0]         st;
    } t_entry;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [VALUE_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_req_type = 1'b0;
    logic signed [KEY_W-1:0] i_key_begin = '0;
    logic signed [KEY_W-1:0] i_key_end = '0;
    logic [VALUE_W-1:0] i_new_value = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [KEY_W-1:0] o_entry_key;
    logic [VALUE_W-1:0] o_entry_value;
    logic o_last_entry;
    logic [1:0] o_status;

    interval_range_map_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [KEY_W-1:0]   map_keys[CAPACITY];
    logic [VALUE_W-1:0] map_vals[CAPACITY];
    int                 map_count;
    logic [VALUE_W-1:0] base_val;

    t_req   pending_reqs[$];
    t_entry expected_dump[$];
    int     error_count = 0;
    int     idle_cycles = 0;
    int     reqs_sent = 0;
    bit     driver_hold = 1'b0;
    int     drv_wait = 0;
    int     mon_wait = 0;
    logic   o_in_stall_q = 1'b1;
    logic   took_req;

    function automatic logic [KEY_W-1:0] ordered(logic [KEY_W-1:0] k);
        return k ^ KEY_MIN;
    endfunction

    function automatic t_status map_assign(t_req r);
        logic [KEY_W-1:0]   nk[CAPACITY+2];
        logic [VALUE_W-1:0] nv[CAPACITY+2];
        logic [KEY_W-1:0]   ob, oe;
        logic [VALUE_W-1:0] prior;
        int n;
        ob = ordered(r.kbeg);
        oe = ordered(r.kend);
        prior = '0;
        n = 0;
        if (!(ob < oe) || ob == '0 || r.val == base_val) return ST_IGNORED;
        for (int i = 0; i < map_count; i++)
            if (ordered(map_keys[i]) <= oe) prior = map_vals[i];
        for (int i = 0; i < map_count; i++)
            if (ordered(map_keys[i]) < ob) begin
                nk[n] = map_keys[i]; nv[n] = map_vals[i]; n++;
            end
        nk[n] = r.kbeg; nv[n] = r.val; n++;
        nk[n] = r.kend; nv[n] = prior; n++;
        for (int i = 0; i < map_count; i++)
            if (ordered(map_keys[i]) > oe && n < CAPACITY + 2) begin
                nk[n] = map_keys[i]; nv[n] = map_vals[i]; n++;
            end
        if (n > CAPACITY) return ST_FULL;
        for (int i = 0; i < n; i++) begin
            map_keys[i] = nk[i]; map_vals[i] = nv[i];
        end
        map_count = n;
        return ST_APPLIED;
    endfunction

    function automatic void map_merge();
        logic [VALUE_W-1:0] prev;
        int n;
        n = 1;
        prev = map_vals[0];
        for (int i = 1; i < map_count; i++) begin
            if (map_vals[i] != prev) begin
                map_keys[n] = map_keys[i]; map_vals[n] = map_vals[i]; n++;
            end
            prev = map_vals[i];
        end
        map_count = n;
    endfunction

    function automatic void predict_dump(t_req r);
        t_status st;
        t_entry e;
        st = ST_APPLIED;
        if (r.kind == REQ_ASSIGN) st = map_assign(r);
        else map_merge();
        for (int i = 0; i < map_count; i++) begin
            e.key = map_keys[i];
            e.val = map_vals[i];
            e.last = (i + 1 == map_count);
            e.st = st;
            expected_dump.push_back(e);
        end
    endfunction

    task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
        error_count++;
    endtask

    // driver: a new request only once the line is free or the last one was taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || !o_in_stall_q) begin
                if (drv_wait > 0) begin
                    i_in_valid <= 1'b0;
                    drv_wait--;
                end else if (driver_hold || pending_reqs.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    i_req_type  <= pending_reqs[0].kind;
                    i_key_begin <= pending_reqs[0].kbeg;
                    i_key_end   <= pending_reqs[0].kend;
                    i_new_value <= pending_reqs[0].val;
                    i_in_valid  <= 1'b1;
                end
            end
            if (mon_wait > 0) begin
                mon_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // monitor and acceptance at the rising edge
    always @(posedge i_clk) begin
        o_in_stall_q <= o_in_stall;
        took_req = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_dump(pending_reqs.pop_front());
            reqs_sent++;
            took_req = 1'b1;
            drv_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            took_req = 1'b1;
            if (expected_dump.size() == 0) begin
                report_mismatch("unexpected entry", o_entry_key, '0);
            end else begin
                t_entry e;
                e = expected_dump.pop_front();
                if (o_entry_key !== e.key) report_mismatch("entry_key", o_entry_key, e.key);
                if (o_entry_value !== e.val)
                    report_mismatch("entry_value", KEY_W'(o_entry_value), KEY_W'(e.val));
                if (o_last_entry !== e.last)
                    report_mismatch("last_entry", KEY_W'(o_last_entry), KEY_W'(e.last));
                if (o_status !== e.st)
                    report_mismatch("status", KEY_W'(o_status), KEY_W'(e.st));
            end
            mon_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        end
        idle_cycles = took_req ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] rand_key(int mode);
        case (mode)
            0: return $urandom_range(0, 40) - 20;
            1: return $urandom;
            default: return KEY_MIN + $urandom_range(0, 3);
        endcase
    endfunction

    function automatic t_req make_req(logic kind, logic [KEY_W-1:0] b, logic [KEY_W-1:0] e,
                                      logic [VALUE_W-1:0] v);
        t_req r;
        r.kind = kind; r.kbeg = b; r.kend = e; r.val = v;
        return r;
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_dump.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_base(logic [VALUE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        base_val = v;
        map_vals[0] = v;
    endtask

    task automatic random_phase(int count);
        t_req r;
        logic [KEY_W-1:0] b;
        int mode;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(0, 9) < 7 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
            b = rand_key(mode);
            r = make_req($urandom_range(0, 7) == 0, b, rand_key(mode), VALUE_W'($urandom));
            if ($urandom_range(0, 9) < 7 && r.kind == REQ_ASSIGN)
                r.kend = b + $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0) r.val = base_val;
            pending_reqs.push_back(r);
        end
    endtask

    initial begin
        base_val = '0;
        map_keys[0] = KEY_MIN;
        map_vals[0] = '0;
        map_count = 1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_base(8'h00);
        pending_reqs.push_back(make_req(REQ_CANON, '0, '0, '0));
        pending_reqs.push_back(make_req(REQ_ASSIGN, 32'd10, 32'd20, 8'hff));
        pending_reqs.push_back(make_req(REQ_ASSIGN, 32'd20, 32'd10, 8'h01));
        pending_reqs.push_back(make_req(REQ_ASSIGN, 32'd5, 32'd5, 8'h01));
        pending_reqs.push_back(make_req(REQ_ASSIGN, KEY_MIN, 32'd3, 8'h01));
        pending_reqs.push_back(make_req(REQ_ASSIGN, KEY_MIN + 1, 32'h7fffffff, 8'h80));
        pending_reqs.push_back(make_req(REQ_ASSIGN, 32'd1, 32'd2, 8'h00));
        pending_reqs.push_back(make_req(REQ_ASSIGN, 32'hffffffff, 32'd15, 8'h55));
        pending_reqs.push_back(make_req(REQ_ASSIGN, 32'd15, 32'd30, 8'h55));
        pending_reqs.push_back(make_req(REQ_CANON, 32'hffffffff, 32'hffffffff, 8'hff));
        for (int i = 0; i < 17; i++)
            pending_reqs.push_back(make_req(REQ_ASSIGN, 100 + 3 * i, 101 + 3 * i,
                                            8'(i + 1)));
        drain();

        // pause until every dump entry is back, then change the base value
        driver_hold = 1'b1;
        write_base(8'hff);
        driver_hold = 1'b0;
        pending_reqs.push_back(make_req(REQ_CANON, '0, '0, '0));
        random_phase(100);
        drain();
        write_base(VALUE_W'($urandom_range(1, 254)));
        random_phase(100);
        drain();
        write_base(8'h00);
        random_phase(100);
        pending_reqs.push_back(make_req(REQ_CANON, '0, '0, '0));
        drain();

        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
